// ----- rtl/fgv_pkg.sv -----
// Shared types and constants for the tile grid disc visibility stamper.
// Holds map geometry, fog bit codes, command codes and the walker request struct.
// No dependencies.
package fgv_pkg;

  localparam int NumTeams  = 4;
  localparam int MaxSide   = 64;
  localparam int MaxRadius = 63;

  localparam int TeamTiles = MaxSide * MaxSide;
  localparam int MemDepth  = NumTeams * TeamTiles;
  localparam int TeamAw    = $clog2(NumTeams);
  localparam int TileAw    = $clog2(TeamTiles);
  localparam int MemAw     = TeamAw + TileAw;
  localparam int CoordW    = $clog2(MaxSide);
  localparam int SideW     = CoordW + 1;
  localparam int RadW      = 6;
  localparam int SqW       = 2 * RadW;

  typedef logic [1:0] fog_t;

  localparam fog_t FogHidden  = 2'b00;
  localparam fog_t SeenBit    = 2'b01;
  localparam fog_t StealthBit = 2'b10;

  typedef enum logic [1:0] {
    CmdClear = 2'd0,
    CmdStamp = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef enum logic {
    CfgMapWidth  = 1'b0,
    CfgMapHeight = 1'b1
  } cfg_e;

  // One tile visit issued by the walker.
  typedef struct packed {
    logic              valid;
    logic              fin;
    logic [TileAw-1:0] tile;
    logic              seen;
    logic              stealth;
  } walk_t;

  function automatic logic [RadW-1:0] clamp_rad(logic [RadW-1:0] r);
    logic [RadW-1:0] res;
    res = r;
    if (int'(r) > MaxRadius) begin
      res = RadW'(MaxRadius);
    end
    return res;
  endfunction

endpackage

// ----- rtl/fgv_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fgv_ram #(
  parameter int Width = 2,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fgv_walker.sv -----
// Tile walker: clips the stamp square to the map and issues one tile a cycle,
// with the seen and stealth masks from the squared distance. Uses fgv_pkg.
module fgv_walker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  logic signed [8:0]         center_x_i,
  input  logic signed [8:0]         center_y_i,
  input  logic [fgv_pkg::RadW-1:0]  sight_i,
  input  logic [fgv_pkg::RadW-1:0]  stealth_i,
  input  logic [fgv_pkg::SideW-1:0] map_w_i,
  input  logic [fgv_pkg::SideW-1:0] map_h_i,
  output fgv_pkg::walk_t            walk_o
);

  typedef enum logic [3:0] {
    W_IDLE  = 4'b0001,
    W_BOUND = 4'b0010,
    W_BASE  = 4'b0100,
    W_RUN   = 4'b1000
  } walk_state_e;

  walk_state_e state_q, state_d;

  logic signed [8:0]               cx_q, cy_q;
  logic [fgv_pkg::RadW-1:0]        reach_q;
  logic [fgv_pkg::SqW-1:0]         sight2_q, stealth2_q;
  logic [fgv_pkg::CoordW-1:0]      lo_x_q, hi_x_q, hi_y_q, x_q, x_d, y_q, y_d;
  logic                            empty_q;
  logic [fgv_pkg::TileAw-1:0]      row_base_q, row_base_d;

  logic [fgv_pkg::RadW-1:0]        sight_c, stealth_c;
  logic signed [9:0]               cx_ext, cy_ext, reach_ext, wm1, hm1;
  logic signed [9:0]               lo_xs, hi_xs, lo_ys, hi_ys, lo_xc, hi_xc, lo_yc, hi_yc;
  logic signed [9:0]               dx, dy, ndx, ndy;
  logic [fgv_pkg::RadW-1:0]        adx, ady;
  logic [fgv_pkg::SqW-1:0]         sqx, sqy;
  logic [fgv_pkg::SqW:0]           d2;

  assign sight_c   = fgv_pkg::clamp_rad(sight_i);
  assign stealth_c = fgv_pkg::clamp_rad(stealth_i);

  // Clip the square to the map.
  always_comb begin
    cx_ext    = {cx_q[8], cx_q};
    cy_ext    = {cy_q[8], cy_q};
    reach_ext = {4'b0, reach_q};
    wm1       = {3'b0, map_w_i} - 10'sd1;
    hm1       = {3'b0, map_h_i} - 10'sd1;
    lo_xs     = cx_ext - reach_ext;
    hi_xs     = cx_ext + reach_ext;
    lo_ys     = cy_ext - reach_ext;
    hi_ys     = cy_ext + reach_ext;
    lo_xc     = (lo_xs < 10'sd0) ? 10'sd0 : lo_xs;
    lo_yc     = (lo_ys < 10'sd0) ? 10'sd0 : lo_ys;
    hi_xc     = (hi_xs > wm1) ? wm1 : hi_xs;
    hi_yc     = (hi_ys > hm1) ? hm1 : hi_ys;
  end

  // Squared distance of the current tile; offsets stay within the reach.
  always_comb begin
    dx  = {4'b0, x_q} - cx_ext;
    dy  = {4'b0, y_q} - cy_ext;
    ndx = -dx;
    ndy = -dy;
    adx = dx[9] ? ndx[fgv_pkg::RadW-1:0] : dx[fgv_pkg::RadW-1:0];
    ady = dy[9] ? ndy[fgv_pkg::RadW-1:0] : dy[fgv_pkg::RadW-1:0];
    sqx = fgv_pkg::SqW'(adx) * fgv_pkg::SqW'(adx);
    sqy = fgv_pkg::SqW'(ady) * fgv_pkg::SqW'(ady);
    d2  = {1'b0, sqx} + {1'b0, sqy};
  end

  always_comb begin
    state_d        = state_q;
    x_d            = x_q;
    y_d            = y_q;
    row_base_d     = row_base_q;
    walk_o.valid   = 1'b0;
    walk_o.fin     = 1'b0;
    walk_o.tile    = row_base_q + fgv_pkg::TileAw'(x_q);
    walk_o.seen    = d2 < {1'b0, sight2_q};
    walk_o.stealth = d2 < {1'b0, stealth2_q};
    case (state_q)
      W_IDLE: begin
        if (go_i) begin
          state_d = W_BOUND;
        end
      end
      W_BOUND: begin
        y_d     = lo_yc[fgv_pkg::CoordW-1:0];
        state_d = W_BASE;
      end
      W_BASE: begin
        row_base_d = fgv_pkg::TileAw'(y_q) * fgv_pkg::TileAw'(map_w_i);
        x_d        = lo_x_q;
        if (empty_q) begin
          walk_o.fin = 1'b1;
          state_d    = W_IDLE;
        end else begin
          state_d = W_RUN;
        end
      end
      W_RUN: begin
        walk_o.valid = 1'b1;
        if (x_q == hi_x_q) begin
          x_d = lo_x_q;
          if (y_q == hi_y_q) begin
            walk_o.fin = 1'b1;
            state_d    = W_IDLE;
          end else begin
            y_d        = y_q + 1'b1;
            row_base_d = row_base_q + fgv_pkg::TileAw'(map_w_i);
          end
        end else begin
          x_d = x_q + 1'b1;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    row_base_q <= row_base_d;
    if (state_q == W_IDLE && go_i) begin
      cx_q       <= center_x_i;
      cy_q       <= center_y_i;
      reach_q    <= (sight_c > stealth_c) ? sight_c : stealth_c;
      sight2_q   <= fgv_pkg::SqW'(sight_c) * fgv_pkg::SqW'(sight_c);
      stealth2_q <= fgv_pkg::SqW'(stealth_c) * fgv_pkg::SqW'(stealth_c);
    end
    if (state_q == W_BOUND) begin
      lo_x_q  <= lo_xc[fgv_pkg::CoordW-1:0];
      hi_x_q  <= hi_xc[fgv_pkg::CoordW-1:0];
      hi_y_q  <= hi_yc[fgv_pkg::CoordW-1:0];
      empty_q <= (lo_xc > hi_xc) || (lo_yc > hi_yc);
    end
  end

endmodule

// ----- rtl/tile_grid_disc_visibility_stamper_top.sv -----
// Visibility stamper top: command sequencer, fog RAM and read-modify-write stage.
// A query reads the RAM then registers the status, a clear zeroes the team's tiles, other
// items go to done_o; a stamp merges one tile a cycle. Items are taken only while idle.
// After reset a clearing pass zeroes all maps with busy high.
// Results are a one-cycle done_o strobe; the receiver cannot stall.
// Depends on fgv_pkg, fgv_ram and fgv_walker.
module tile_grid_disc_visibility_stamper_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                cmd_i,
  input  logic [1:0]                team_i,
  input  logic signed [8:0]         center_x_i,
  input  logic signed [8:0]         center_y_i,
  input  logic [5:0]                sight_radius_i,
  input  logic [5:0]                stealth_radius_i,
  input  logic [15:0]               query_index_i,
  output logic                      done_o,
  output logic [1:0]                tile_status_o,
  output logic                      tile_visible_o,
  output logic                      index_valid_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [fgv_pkg::SideW-1:0] cfg_wdata_i
);

  typedef enum logic [7:0] {
    T_INIT  = 8'b0000_0001,
    T_IDLE  = 8'b0000_0010,
    T_CLEAR = 8'b0000_0100,
    T_STAMP = 8'b0000_1000,
    T_DRAIN = 8'b0001_0000,
    T_QRD   = 8'b0010_0000,
    T_QRESP = 8'b0100_0000,
    T_DONE  = 8'b1000_0000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [fgv_pkg::MemAw-1:0]  cnt_q, cnt_d;
  logic [fgv_pkg::SideW-1:0]  map_w_q, map_h_q, cfg_clamped;
  logic [fgv_pkg::TeamAw-1:0] team_q;
  logic [15:0]                qidx_q;
  logic                       qok_q;
  logic [15:0]                tile_count;
  logic                       team_ok;
  logic                       accept, go;

  logic                       s1_valid_q;
  logic [fgv_pkg::MemAw-1:0]  s1_addr_q;
  logic                       s1_seen_q, s1_stealth_q;
  fgv_pkg::fog_t              merged;

  fgv_pkg::fog_t              status_q;
  logic                       ivalid_q;

  logic                       ram_we, ram_re;
  logic [fgv_pkg::MemAw-1:0]  ram_waddr, ram_raddr;
  fgv_pkg::fog_t              ram_wdata, ram_rdata;

  fgv_pkg::walk_t             walk;

  assign busy       = (state_q != T_IDLE);
  assign accept     = start && !busy;
  assign team_ok    = int'(team_i) < fgv_pkg::NumTeams;
  assign tile_count = 16'(map_w_q) * 16'(map_h_q);
  assign go         = accept && (fgv_pkg::cmd_e'(cmd_i) == fgv_pkg::CmdStamp) && team_ok;

  fgv_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .center_x_i (center_x_i),
    .center_y_i (center_y_i),
    .sight_i    (sight_radius_i),
    .stealth_i  (stealth_radius_i),
    .map_w_i    (map_w_q),
    .map_h_i    (map_h_q),
    .walk_o     (walk)
  );

  fgv_ram #(
    .Width ($bits(fgv_pkg::fog_t)),
    .Depth (fgv_pkg::MemDepth)
  ) u_fog_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Merge the masks into the stored bits; stealth alone reads as hidden.
  always_comb begin
    merged = ram_rdata;
    if (s1_seen_q) begin
      merged = merged | fgv_pkg::SeenBit;
    end
    if (s1_stealth_q) begin
      merged = merged | fgv_pkg::StealthBit;
    end
    if (merged == fgv_pkg::StealthBit) begin
      merged = fgv_pkg::FogHidden;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s1_addr_q;
    ram_wdata = merged;
    ram_re    = 1'b0;
    ram_raddr = {team_q, walk.tile};
    if (state_q == T_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q;
      ram_wdata = fgv_pkg::FogHidden;
    end else if (state_q == T_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = {team_q, cnt_q[fgv_pkg::TileAw-1:0]};
      ram_wdata = fgv_pkg::FogHidden;
    end else if (s1_valid_q) begin
      ram_we = 1'b1;
    end
    if (state_q == T_STAMP) begin
      ram_re = walk.valid;
    end else if (state_q == T_QRD) begin
      ram_re    = 1'b1;
      ram_raddr = {team_q, qidx_q[fgv_pkg::TileAw-1:0]};
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      T_INIT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == fgv_pkg::MemAw'(fgv_pkg::MemDepth - 1)) begin
          state_d = T_IDLE;
        end
      end
      T_IDLE: begin
        if (start) begin
          cnt_d = '0;
          case (fgv_pkg::cmd_e'(cmd_i))
            fgv_pkg::CmdClear: state_d = team_ok ? T_CLEAR : T_DONE;
            fgv_pkg::CmdStamp: state_d = team_ok ? T_STAMP : T_DONE;
            fgv_pkg::CmdQuery: state_d = T_QRD;
            default:           state_d = T_DONE;
          endcase
        end
      end
      T_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (&cnt_q[fgv_pkg::TileAw-1:0]) begin
          state_d = T_DONE;
        end
      end
      T_STAMP: begin
        if (walk.fin) begin
          state_d = T_DRAIN;
        end
      end
      T_DRAIN: state_d = T_DONE;
      T_QRD:   state_d = T_QRESP;
      T_QRESP: state_d = T_DONE;
      T_DONE:  state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_INIT;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= (state_q == T_STAMP) && walk.valid;
    end
  end

  // Hold the dimensions; oversized values saturate.
  assign cfg_clamped = (int'(cfg_wdata_i) > fgv_pkg::MaxSide) ?
                       fgv_pkg::SideW'(fgv_pkg::MaxSide) : cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= fgv_pkg::SideW'(fgv_pkg::MaxSide);
      map_h_q <= fgv_pkg::SideW'(fgv_pkg::MaxSide);
    end else if (cfg_we_i) begin
      case (fgv_pkg::cfg_e'(cfg_idx_i))
        fgv_pkg::CfgMapWidth:  map_w_q <= cfg_clamped;
        fgv_pkg::CfgMapHeight: map_h_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q    <= {team_q, walk.tile};
    s1_seen_q    <= walk.seen;
    s1_stealth_q <= walk.stealth;
    if (accept) begin
      team_q   <= fgv_pkg::TeamAw'(team_i);
      qidx_q   <= query_index_i;
      status_q <= fgv_pkg::FogHidden;
      ivalid_q <= 1'b0;
    end
    if (state_q == T_QRD) begin
      qok_q <= (int'(team_q) < fgv_pkg::NumTeams) && (qidx_q < tile_count);
    end
    if (state_q == T_QRESP) begin
      status_q <= qok_q ? ram_rdata : fgv_pkg::FogHidden;
      ivalid_q <= qok_q;
    end
  end

  assign done_o         = (state_q == T_DONE);
  assign tile_status_o  = status_q;
  assign tile_visible_o = status_q[0];
  assign index_valid_o  = ivalid_q;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("done strobe outside a command");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done strobe longer than one cycle");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write of one tile in the same cycle");

  a_invalid_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !index_valid_o) |-> (tile_status_o == fgv_pkg::FogHidden))
    else $error("status reported for an invalid index");

  a_stamp_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_DONE) |-> !s1_valid_q) else $error("write-back pending at done");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for tile_grid_disc_visibility_stamper_top: clears, disc stamps and
// tile queries over many map shapes, checked against a behavioral fog map kept here.
// Depends on fgv_pkg and the stamper RTL.
module tb;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int CycleLimit = 20_000_000;
  localparam int MaxGap = 17;
  localparam int ItemsPerShape = 80;

  typedef struct {
    logic [1:0]        cmd;
    logic [1:0]        team;
    logic signed [8:0] cx;
    logic signed [8:0] cy;
    logic [5:0]        sight;
    logic [5:0]        stealth;
    logic [15:0]       qidx;
  } fog_item_t;

  typedef struct packed {
    fgv_pkg::fog_t status;
    logic          visible;
    logic          valid;
  } tile_report_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                cmd_i;
  logic [1:0]                team_i;
  logic signed [8:0]         center_x_i;
  logic signed [8:0]         center_y_i;
  logic [5:0]                sight_radius_i;
  logic [5:0]                stealth_radius_i;
  logic [15:0]               query_index_i;
  logic                      done_o;
  logic [1:0]                tile_status_o;
  logic                      tile_visible_o;
  logic                      index_valid_o;
  logic                      cfg_we_i;
  logic                      cfg_idx_i;
  logic [fgv_pkg::SideW-1:0] cfg_wdata_i;

  // Behavioral fog map, updated as items are accepted, and map geometry from register writes.
  bit [1:0]     fog_map [fgv_pkg::MemDepth];
  int           map_w = fgv_pkg::MaxSide;
  int           map_h = fgv_pkg::MaxSide;
  tile_report_t predicted_reports [$];

  int  errors = 0;
  int  cycle_cnt = 0;
  int  n_items = 0;
  int  n_stamps = 0;
  int  n_queries = 0;
  int  n_hits = 0;
  int  n_clears = 0;
  int  n_reg_writes = 0;
  bit  no_idle = 1'b0;

  tile_grid_disc_visibility_stamper_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cmd_i            (cmd_i),
    .team_i           (team_i),
    .center_x_i       (center_x_i),
    .center_y_i       (center_y_i),
    .sight_radius_i   (sight_radius_i),
    .stealth_radius_i (stealth_radius_i),
    .query_index_i    (query_index_i),
    .done_o           (done_o),
    .tile_status_o    (tile_status_o),
    .tile_visible_o   (tile_visible_o),
    .index_valid_o    (index_valid_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               predicted_reports.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int side_limit(logic [fgv_pkg::SideW-1:0] v);
    return (int'(v) > fgv_pkg::MaxSide) ? fgv_pkg::MaxSide : int'(v);
  endfunction

  function automatic int radius_limit(logic [5:0] r);
    return (int'(r) > fgv_pkg::MaxRadius) ? fgv_pkg::MaxRadius : int'(r);
  endfunction

  function automatic void reveal_disc(int base, int cx, int cy, int sight, int stealth);
    int            reach;
    int            x;
    int            y;
    int            d2;
    int            pos;
    fgv_pkg::fog_t v;
    reach = (sight > stealth) ? sight : stealth;
    for (int dy = -reach; dy <= reach; dy++) begin
      y = cy + dy;
      if (y >= 0 && y < map_h) begin
        for (int dx = -reach; dx <= reach; dx++) begin
          x   = cx + dx;
          d2  = dx * dx + dy * dy;
          pos = x + y * map_w;
          if (x >= 0 && x < map_w && pos < fgv_pkg::TeamTiles) begin
            v = fog_map[base + pos];
            if (d2 < sight * sight) v |= fgv_pkg::SeenBit;
            if (d2 < stealth * stealth) v |= fgv_pkg::StealthBit;
            // a tile seen only in stealth falls back to hidden
            if (v == fgv_pkg::StealthBit) v = fgv_pkg::FogHidden;
            fog_map[base + pos] = v;
          end
        end
      end
    end
  endfunction

  // Apply one accepted item to the fog map and return the report it yields.
  function automatic tile_report_t apply_item(fog_item_t it);
    tile_report_t rep;
    int           base;
    int           qi;
    bit           team_ok;
    rep     = '0;
    team_ok = int'(it.team) < fgv_pkg::NumTeams;
    base    = int'(it.team) * fgv_pkg::TeamTiles;
    qi      = int'(it.qidx);
    case (it.cmd)
      fgv_pkg::CmdClear: begin
        if (team_ok) begin
          for (int i = 0; i < fgv_pkg::TeamTiles; i++) fog_map[base + i] = fgv_pkg::FogHidden;
        end
      end
      fgv_pkg::CmdStamp: begin
        if (team_ok) begin
          reveal_disc(base, int'(it.cx), int'(it.cy), radius_limit(it.sight),
                      radius_limit(it.stealth));
        end
      end
      fgv_pkg::CmdQuery: begin
        if (team_ok && qi < map_w * map_h && qi < fgv_pkg::TeamTiles) begin
          rep.status  = fog_map[base + qi];
          rep.visible = rep.status[0];
          rep.valid   = 1'b1;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Track register writes and accepted items, and check every done strobe.
  always @(posedge clk_i) begin : tile_monitor
    tile_report_t got;
    tile_report_t want;
    fog_item_t    it;
    if (rst_ni) begin
      if (done_o) begin
        got = '{tile_status_o, tile_visible_o, index_valid_o};
        if (predicted_reports.size() == 0) begin
          errors++;
          $display("%0t: result with no item pending: status %0d visible %0d valid %0d",
                   $time, got.status, got.visible, got.valid);
        end else begin
          want = predicted_reports.pop_front();
          if (got.status !== want.status || got.visible !== want.visible ||
              got.valid !== want.valid) begin
            errors++;
            $display("%0t: mismatch expected status %0d visible %0d valid %0d, got %0d %0d %0d",
                     $time, want.status, want.visible, want.valid,
                     got.status, got.visible, got.valid);
          end
        end
      end
      if (cfg_we_i) begin
        n_reg_writes++;
        if (cfg_idx_i == fgv_pkg::CfgMapWidth) map_w = side_limit(cfg_wdata_i);
        else map_h = side_limit(cfg_wdata_i);
      end
      if (start && !busy) begin
        it = '{cmd_i, team_i, center_x_i, center_y_i, sight_radius_i, stealth_radius_i,
               query_index_i};
        want = apply_item(it);
        predicted_reports.push_back(want);
        n_items++;
        if (it.cmd == fgv_pkg::CmdStamp) n_stamps++;
        if (it.cmd == fgv_pkg::CmdClear) n_clears++;
        if (it.cmd == fgv_pkg::CmdQuery) n_queries++;
        if (want.valid) n_hits++;
      end
    end
  end

  // Leave start high on return so a following item can go back to back.
  task automatic send_item(fog_item_t it);
    int gap;
    gap = no_idle ? 0 : int'($urandom_range(0, MaxGap));
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_i            <= it.cmd;
    team_i           <= it.team;
    center_x_i       <= it.cx;
    center_y_i       <= it.cy;
    sight_radius_i   <= it.sight;
    stealth_radius_i <= it.stealth;
    query_index_i    <= it.qidx;
    start            <= 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic fog_item_t filler_item();
    fog_item_t it;
    it.cmd     = CmdUnused;
    it.team    = 2'($urandom);
    it.cx      = 9'($urandom);
    it.cy      = 9'($urandom);
    it.sight   = 6'($urandom);
    it.stealth = 6'($urandom);
    it.qidx    = 16'($urandom);
    return it;
  endfunction

  task automatic query_at(int team, int idx);
    fog_item_t it;
    it      = filler_item();
    it.cmd  = fgv_pkg::CmdQuery;
    it.team = 2'(team);
    it.qidx = 16'(idx);
    send_item(it);
  endtask

  task automatic stamp_at(int team, int cx, int cy, int sight, int stealth);
    fog_item_t it;
    it         = filler_item();
    it.cmd     = fgv_pkg::CmdStamp;
    it.team    = 2'(team);
    it.cx      = 9'(cx);
    it.cy      = 9'(cy);
    it.sight   = 6'(sight);
    it.stealth = 6'(stealth);
    send_item(it);
  endtask

  task automatic plain_cmd(logic [1:0] cmd, int team);
    fog_item_t it;
    it      = filler_item();
    it.cmd  = cmd;
    it.team = 2'(team);
    send_item(it);
  endtask

  // Drop start, then hold until every report is back and the block is idle.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (predicted_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_reg(fgv_pkg::cfg_e idx, logic [fgv_pkg::SideW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= fgv_pkg::SideW'($urandom);
  endtask

  function automatic int pick_radius();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 80) return int'($urandom_range(0, 8));
    if (r < 95) return int'($urandom_range(0, 20));
    return int'($urandom_range(0, 63));
  endfunction

  function automatic fog_item_t random_item();
    fog_item_t it;
    int        pick;
    int        tiles;
    it    = filler_item();
    pick  = int'($urandom_range(0, 99));
    tiles = map_w * map_h;
    if (pick < 45) begin
      it.cmd = fgv_pkg::CmdQuery;
      if (tiles > 0 && $urandom_range(0, 99) < 85) begin
        it.qidx = 16'($urandom_range(0, tiles - 1));
      end
    end else if (pick < 92) begin
      it.cmd = fgv_pkg::CmdStamp;
      // keep most centres on or near the map
      if ($urandom_range(0, 9) != 0) begin
        it.cx = 9'(int'($urandom_range(0, map_w + 7)) - 4);
        it.cy = 9'(int'($urandom_range(0, map_h + 7)) - 4);
      end
      it.sight   = 6'(pick_radius());
      it.stealth = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'(pick_radius());
    end else if (pick < 96) begin
      it.cmd = fgv_pkg::CmdClear;
    end
    return it;
  endfunction

  task automatic test_reset_state();
    query_at(0, 0);
    query_at(3, 4095);
    query_at(1, 4096);
    query_at(2, 65535);
    drain();
  endtask

  task automatic test_directed();
    stamp_at(0, 10, 10, 3, 0);
    query_at(0, 10 + 10 * 64);
    query_at(0, 13 + 10 * 64);  // on the sight boundary, stays hidden
    query_at(0, 12 + 10 * 64);
    stamp_at(1, 20, 20, 2, 5);  // stealth ring outside sight reverts to hidden
    query_at(1, 20 + 20 * 64);
    query_at(1, 24 + 20 * 64);
    stamp_at(2, 0, 0, 63, 63);
    query_at(2, 62);
    query_at(2, 63 + 63 * 64);
    stamp_at(0, -256, -256, 63, 63);
    stamp_at(0, 255, 255, 63, 0);
    stamp_at(0, 63, 63, 1, 0);
    query_at(0, 4095);
    stamp_at(3, 5, 5, 0, 0);
    query_at(3, 5 + 5 * 64);
    plain_cmd(CmdUnused, 2);
    plain_cmd(fgv_pkg::CmdClear, 2);
    query_at(2, 62);
    stamp_at(0, 0, 0, 0, 4);
    query_at(0, 1);
    drain();
  endtask

  // Walk several map shapes, extremes included; stored tiles carry over between them.
  task automatic test_map_shapes();
    int w_list [11] = '{1, 0, 5, 127, 65, 33, 64, 1, 100, 0, 64};
    int h_list [11] = '{1, 5, 0, 100, 64, 17, 1, 64, 2, 127, 64};
    int w;
    int h;
    for (int s = 0; s < 12; s++) begin
      w = (s < 11) ? w_list[s] : int'($urandom_range(0, 127));
      h = (s < 11) ? h_list[s] : int'($urandom_range(0, 127));
      write_reg(fgv_pkg::CfgMapWidth, fgv_pkg::SideW'(w));
      write_reg(fgv_pkg::CfgMapHeight, fgv_pkg::SideW'(h));
      for (int i = 0; i < ItemsPerShape; i++) begin
        if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_item(random_item());
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    cmd_i            = fgv_pkg::CmdClear;
    team_i           = '0;
    center_x_i       = '0;
    center_y_i       = '0;
    sight_radius_i   = '0;
    stealth_radius_i = '0;
    query_index_i    = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = fgv_pkg::CfgMapWidth;
    cfg_wdata_i      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // hold through the power-up clearing pass
    @(posedge clk_i);
    while (busy) @(posedge clk_i);

    test_reset_state();
    test_directed();
    test_map_shapes();

    $display("ran %0d items: %0d stamps, %0d clears, %0d queries (%0d inside the map)",
             n_items, n_stamps, n_clears, n_queries, n_hits);
    $display("map size registers written %0d times, %0d mismatches", n_reg_writes, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- tile_grid_disc_visibility_stamper_top.f -----
rtl/fgv_pkg.sv
rtl/fgv_ram.sv
rtl/fgv_walker.sv
rtl/tile_grid_disc_visibility_stamper_top.sv
tb/tb.sv
